// ----- sv/wnpm_pkg.sv -----
`timescale 1ns / 1ps

package wnpm_pkg;

    localparam int MAX_POINTS  = 16384;
    localparam int WINDOW_HALF = 50;

    localparam int IDX_W     = 14;
    localparam int COORD_W   = 16;
    localparam int GRID_W    = 8;
    localparam int COUNT_W   = 15;
    localparam int DIST_W    = 34;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;

    localparam int ADDR_W    = $clog2(MAX_POINTS);
    // Wide enough for a row base plus a column, and for the clamped count itself.
    localparam int SLOT_W    = (ADDR_W + 1 > IDX_W + 1) ? ADDR_W + 1 : IDX_W + 1;
    // Column arithmetic must hold the last column plus the half window.
    localparam int J_W       = $clog2((1 << GRID_W) + WINDOW_HALF);
    localparam int DIV_CNT_W = $clog2(IDX_W + 1);
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH = 1'b0,
        CFG_REF_COUNT  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_BASE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic [SLOT_W-1:0] slot;
    } rd_tag_t;

    typedef struct packed {
        point_t            pt;
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] distance;
    } best_t;

endpackage

// ----- sv/wnpm_if.sv -----
`timescale 1ns / 1ps

interface wnpm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [wnpm_pkg::IDX_W-1:0]           point_index;
    logic signed [wnpm_pkg::COORD_W-1:0]  coord_x;
    logic signed [wnpm_pkg::COORD_W-1:0]  coord_y;
    logic signed [wnpm_pkg::COORD_W-1:0]  coord_z;

    modport source (output valid, cmd, point_index, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, cmd, point_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface wnpm_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wnpm_pkg::COORD_W-1:0]  match_x;
    logic signed [wnpm_pkg::COORD_W-1:0]  match_y;
    logic signed [wnpm_pkg::COORD_W-1:0]  match_z;
    logic [wnpm_pkg::IDX_W-1:0]           match_index;
    logic [wnpm_pkg::DIST_W-1:0]          match_distance;

    modport source (output valid, match_x, match_y, match_z, match_index, match_distance,
                    input ready);
    modport sink   (input valid, match_x, match_y, match_z, match_index, match_distance,
                    output ready);
endinterface

// ----- sv/wnpm_divider.sv -----
`timescale 1ns / 1ps

module wnpm_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [wnpm_pkg::IDX_W-1:0]  dividend,
    input  logic [wnpm_pkg::GRID_W-1:0] divisor,
    output logic                        done,
    output logic [wnpm_pkg::IDX_W-1:0]  quotient,
    output logic [wnpm_pkg::GRID_W-1:0] remainder
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           done_reg;
    logic                           done_next;
    logic [wnpm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [wnpm_pkg::DIV_CNT_W-1:0] cnt_next;
    logic [wnpm_pkg::IDX_W-1:0]     dvd_reg;
    logic [wnpm_pkg::IDX_W-1:0]     dvd_next;
    logic [wnpm_pkg::GRID_W-1:0]    rem_reg;
    logic [wnpm_pkg::GRID_W-1:0]    rem_next;
    logic [wnpm_pkg::GRID_W-1:0]    dsr_reg;
    logic [wnpm_pkg::GRID_W:0]      shifted;
    logic [wnpm_pkg::GRID_W:0]      diff;
    logic                           fits;

    // Restoring division, one quotient bit per cycle, MSB first.
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[wnpm_pkg::IDX_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        fits      = (shifted >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = wnpm_pkg::DIV_CNT_W'(wnpm_pkg::IDX_W);
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[wnpm_pkg::IDX_W-2:0], fits};
            rem_next = fits ? diff[wnpm_pkg::GRID_W-1:0] : shifted[wnpm_pkg::GRID_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == wnpm_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/wnpm_store.sv -----
`timescale 1ns / 1ps

module wnpm_store (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [wnpm_pkg::ADDR_W-1:0] wr_addr,
    input  wnpm_pkg::point_t            wr_data,
    input  logic                        rd_en,
    input  logic [wnpm_pkg::ADDR_W-1:0] rd_addr,
    output wnpm_pkg::point_t            rd_data
);

    wnpm_pkg::point_t mem [wnpm_pkg::MAX_POINTS];
    wnpm_pkg::point_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/wnpm_dist.sv -----
`timescale 1ns / 1ps

module wnpm_dist (
    input  logic              clk,
    input  logic              rst_n,
    input  wnpm_pkg::point_t  query,
    input  wnpm_pkg::rd_tag_t tag_in,
    input  wnpm_pkg::point_t  rd_data,
    output logic              busy,
    output wnpm_pkg::best_t   best
);

    wnpm_pkg::rd_tag_t                s1_tag_reg;
    wnpm_pkg::rd_tag_t                s2_tag_reg;
    wnpm_pkg::point_t                 s2_pt_reg;
    logic [wnpm_pkg::SQ_W-1:0]        sqx_reg;
    logic [wnpm_pkg::SQ_W-1:0]        sqy_reg;
    logic [wnpm_pkg::SQ_W-1:0]        sqz_reg;
    logic [wnpm_pkg::SQ_W-1:0]        sqx_next;
    logic [wnpm_pkg::SQ_W-1:0]        sqy_next;
    logic [wnpm_pkg::SQ_W-1:0]        sqz_next;
    logic [wnpm_pkg::DIST_W-1:0]      sum;
    wnpm_pkg::best_t                  best_reg;

    always_comb
    begin
        logic signed [wnpm_pkg::DIFF_W-1:0]   dx;
        logic signed [wnpm_pkg::DIFF_W-1:0]   dy;
        logic signed [wnpm_pkg::DIFF_W-1:0]   dz;
        logic signed [2*wnpm_pkg::DIFF_W-1:0] px;
        logic signed [2*wnpm_pkg::DIFF_W-1:0] py;
        logic signed [2*wnpm_pkg::DIFF_W-1:0] pz;
        dx = $signed({query.x[wnpm_pkg::COORD_W-1], query.x})
           - $signed({rd_data.x[wnpm_pkg::COORD_W-1], rd_data.x});
        dy = $signed({query.y[wnpm_pkg::COORD_W-1], query.y})
           - $signed({rd_data.y[wnpm_pkg::COORD_W-1], rd_data.y});
        dz = $signed({query.z[wnpm_pkg::COORD_W-1], query.z})
           - $signed({rd_data.z[wnpm_pkg::COORD_W-1], rd_data.z});
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
        // A square of a 17-bit difference never exceeds 32 bits.
        sqx_next = px[wnpm_pkg::SQ_W-1:0];
        sqy_next = py[wnpm_pkg::SQ_W-1:0];
        sqz_next = pz[wnpm_pkg::SQ_W-1:0];
    end

    assign sum = wnpm_pkg::DIST_W'(sqx_reg) + wnpm_pkg::DIST_W'(sqy_reg)
               + wnpm_pkg::DIST_W'(sqz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= tag_in;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_pt_reg <= rd_data;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        sqz_reg   <= sqz_next;
        // The first candidate of a request seeds the best match; later ones win only
        // when strictly closer.
        if (s2_tag_reg.valid && (s2_tag_reg.first || (sum < best_reg.distance)))
        begin
            best_reg.pt       <= s2_pt_reg;
            best_reg.slot     <= s2_tag_reg.slot;
            best_reg.distance <= sum;
        end
    end

    assign busy = s1_tag_reg.valid | s2_tag_reg.valid;
    assign best = best_reg;

endmodule

// ----- sv/wnpm_ctrl.sv -----
`timescale 1ns / 1ps

module wnpm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    wnpm_req_if.sink                    req,
    wnpm_rsp_if.source                  rsp,
    input  logic [wnpm_pkg::GRID_W-1:0] grid_width,
    input  logic [wnpm_pkg::COUNT_W-1:0] ref_count,
    output logic                        wr_en,
    output logic [wnpm_pkg::ADDR_W-1:0] wr_addr,
    output wnpm_pkg::point_t            wr_data,
    output logic                        div_start,
    output logic [wnpm_pkg::IDX_W-1:0]  div_dividend,
    output logic [wnpm_pkg::GRID_W-1:0] div_divisor,
    input  logic                        div_done,
    input  logic [wnpm_pkg::IDX_W-1:0]  div_quotient,
    input  logic [wnpm_pkg::GRID_W-1:0] div_remainder,
    output wnpm_pkg::rd_tag_t           rd_tag,
    output wnpm_pkg::point_t            query,
    input  logic                        dist_busy,
    input  wnpm_pkg::best_t             best
);

    wnpm_pkg::state_t                        state_reg;
    wnpm_pkg::state_t                        state_next;
    logic                                    rsp_valid_reg;
    logic                                    rsp_valid_next;
    logic                                    load_rsp;
    logic                                    accept;
    logic [wnpm_pkg::GRID_W-1:0]             w_eff;
    logic [wnpm_pkg::GRID_W-1:0]             width_reg;
    logic [wnpm_pkg::SLOT_W-1:0]             ref_ext;
    logic [wnpm_pkg::SLOT_W-1:0]             cnt_lim;
    logic [wnpm_pkg::SLOT_W-1:0]             cnt_eff;
    logic [wnpm_pkg::SLOT_W-1:0]             cnt_last;
    logic [wnpm_pkg::SLOT_W-1:0]             pidx_ext;
    logic [wnpm_pkg::IDX_W+wnpm_pkg::GRID_W-1:0] base_prod;
    logic [wnpm_pkg::SLOT_W-1:0]             base_reg;
    logic [wnpm_pkg::J_W-1:0]                col;
    logic [wnpm_pkg::J_W-1:0]                lo;
    logic [wnpm_pkg::J_W-1:0]                hi_cand;
    logic [wnpm_pkg::J_W-1:0]                hi;
    logic [wnpm_pkg::J_W-1:0]                j_reg;
    logic [wnpm_pkg::J_W-1:0]                j_inc;
    logic [wnpm_pkg::J_W-1:0]                hi_reg;
    logic [wnpm_pkg::SLOT_W-1:0]             slot_raw;
    logic [wnpm_pkg::SLOT_W-1:0]             slot_clamped;
    wnpm_pkg::point_t                        query_reg;
    wnpm_pkg::point_t                        out_pt_reg;
    logic [wnpm_pkg::IDX_W-1:0]              out_idx_reg;
    logic [wnpm_pkg::DIST_W-1:0]             out_dist_reg;

    assign accept   = req.valid && req.ready;
    assign w_eff    = (grid_width == '0) ? wnpm_pkg::GRID_W'(1) : grid_width;
    assign ref_ext  = wnpm_pkg::SLOT_W'(ref_count);
    assign cnt_lim  = (ref_ext > wnpm_pkg::SLOT_W'(wnpm_pkg::MAX_POINTS))
                    ? wnpm_pkg::SLOT_W'(wnpm_pkg::MAX_POINTS) : ref_ext;
    assign cnt_eff  = (cnt_lim == '0) ? wnpm_pkg::SLOT_W'(1) : cnt_lim;
    assign cnt_last = cnt_eff - 1'b1;
    assign pidx_ext = wnpm_pkg::SLOT_W'(req.point_index);

    // Loads go straight into the store; slots past the store are dropped.
    assign wr_en   = accept && (req.cmd == wnpm_pkg::CMD_LOAD)
                   && (pidx_ext < wnpm_pkg::SLOT_W'(wnpm_pkg::MAX_POINTS));
    assign wr_addr = pidx_ext[wnpm_pkg::ADDR_W-1:0];
    assign wr_data = '{x: req.coord_x, y: req.coord_y, z: req.coord_z};

    assign div_start    = accept && (req.cmd == wnpm_pkg::CMD_QUERY);
    assign div_dividend = req.point_index;
    assign div_divisor  = w_eff;

    // Row base and the column window, taken when the divider finishes.
    assign base_prod = (wnpm_pkg::IDX_W + wnpm_pkg::GRID_W)'(div_quotient)
                     * (wnpm_pkg::IDX_W + wnpm_pkg::GRID_W)'(width_reg);
    assign col       = wnpm_pkg::J_W'(div_remainder);
    assign lo        = (col >= wnpm_pkg::J_W'(wnpm_pkg::WINDOW_HALF))
                     ? col - wnpm_pkg::J_W'(wnpm_pkg::WINDOW_HALF) : '0;
    assign hi_cand   = col + wnpm_pkg::J_W'(wnpm_pkg::WINDOW_HALF);
    assign hi        = (hi_cand > wnpm_pkg::J_W'(width_reg))
                     ? wnpm_pkg::J_W'(width_reg) : hi_cand;

    assign j_inc        = j_reg + 1'b1;
    assign slot_raw     = base_reg + wnpm_pkg::SLOT_W'(j_reg);
    assign slot_clamped = (slot_raw >= cnt_eff) ? cnt_last : slot_raw;

    always_comb
    begin
        state_next = state_reg;
        rd_tag     = '0;
        load_rsp   = 1'b0;
        req.ready  = (state_reg == wnpm_pkg::ST_IDLE);
        case (state_reg)
            wnpm_pkg::ST_IDLE:
            begin
                if (accept && (req.cmd == wnpm_pkg::CMD_QUERY))
                begin
                    state_next = wnpm_pkg::ST_DIVIDE;
                end
            end
            wnpm_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = wnpm_pkg::ST_BASE;
                end
            end
            wnpm_pkg::ST_BASE:
            begin
                // Slot zero is always the starting candidate.
                rd_tag.valid = 1'b1;
                rd_tag.first = 1'b1;
                rd_tag.slot  = '0;
                state_next   = wnpm_pkg::ST_SCAN;
            end
            wnpm_pkg::ST_SCAN:
            begin
                rd_tag.valid = 1'b1;
                rd_tag.first = 1'b0;
                rd_tag.slot  = slot_clamped;
                if (j_inc == hi_reg)
                begin
                    state_next = wnpm_pkg::ST_DRAIN;
                end
            end
            wnpm_pkg::ST_DRAIN:
            begin
                if (!dist_busy)
                begin
                    state_next = wnpm_pkg::ST_DONE;
                end
            end
            wnpm_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_rsp   = 1'b1;
                    state_next = wnpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wnpm_pkg::ST_IDLE;
            end
        endcase
        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wnpm_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            query_reg <= wr_data;
            width_reg <= w_eff;
        end
        if ((state_reg == wnpm_pkg::ST_DIVIDE) && div_done)
        begin
            base_reg <= wnpm_pkg::SLOT_W'(base_prod);
            j_reg    <= lo;
            hi_reg   <= hi;
        end
        else if (state_reg == wnpm_pkg::ST_SCAN)
        begin
            j_reg <= j_inc;
        end
        if (load_rsp)
        begin
            out_pt_reg   <= best.pt;
            out_idx_reg  <= best.slot[wnpm_pkg::IDX_W-1:0];
            out_dist_reg <= best.distance;
        end
    end

    assign query              = query_reg;
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.match_x        = out_pt_reg.x;
    assign rsp.match_y        = out_pt_reg.y;
    assign rsp.match_z        = out_pt_reg.z;
    assign rsp.match_index    = out_idx_reg;
    assign rsp.match_distance = out_dist_reg;

endmodule

// ----- sv/windowed_nearest_point_match.sv -----
`timescale 1ns / 1ps

// Windowed nearest point match. A load request (cmd 0) writes one 3D reference point
// into a 16384-entry store and produces no response. A query request (cmd 1) splits
// its grid position into row and column by the grid width, compares the query against
// slot 0 and then against every slot of the same row within 50 columns below and 49
// above (clipped to the row), and returns the closest point (the earlier candidate
// wins a tie), its slot and the squared distance. Slots past ref_count read the last
// loaded slot. A query occupies the block while the row/column split runs in a
// one-bit-per-cycle divider, the scan reads one store entry per cycle through the
// single read port over the clipped window (at most 100 slots wide), and the distance
// pipeline drains. A finished response sits in an output register, so the next
// request is taken while it waits. Configuration writes belong in idle periods only.
module windowed_nearest_point_match (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [wnpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wnpm_pkg::CFG_W-1:0]   cfg_data,
    wnpm_req_if.sink                     req,
    wnpm_rsp_if.source                   rsp
);

    logic [wnpm_pkg::GRID_W-1:0]  grid_width_reg;
    logic [wnpm_pkg::COUNT_W-1:0] ref_count_reg;

    logic                         wr_en;
    logic [wnpm_pkg::ADDR_W-1:0]  wr_addr;
    wnpm_pkg::point_t             wr_data;
    logic                         div_start;
    logic [wnpm_pkg::IDX_W-1:0]   div_dividend;
    logic [wnpm_pkg::GRID_W-1:0]  div_divisor;
    logic                         div_done;
    logic [wnpm_pkg::IDX_W-1:0]   div_quotient;
    logic [wnpm_pkg::GRID_W-1:0]  div_remainder;
    wnpm_pkg::rd_tag_t            rd_tag;
    wnpm_pkg::point_t             rd_data;
    wnpm_pkg::point_t             query;
    logic                         dist_busy;
    wnpm_pkg::best_t              best;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= wnpm_pkg::GRID_W'(128);
            ref_count_reg  <= wnpm_pkg::COUNT_W'(16384);
        end
        else if (cfg_wr_en)
        begin
            case (wnpm_pkg::cfg_reg_t'(cfg_index))
                wnpm_pkg::CFG_GRID_WIDTH: grid_width_reg <= cfg_data[wnpm_pkg::GRID_W-1:0];
                wnpm_pkg::CFG_REF_COUNT:  ref_count_reg  <= cfg_data[wnpm_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    wnpm_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .grid_width    (grid_width_reg),
        .ref_count     (ref_count_reg),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .rd_tag        (rd_tag),
        .query         (query),
        .dist_busy     (dist_busy),
        .best          (best)
    );

    wnpm_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    wnpm_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_tag.valid),
        .rd_addr (rd_tag.slot[wnpm_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    wnpm_dist u_dist (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query),
        .tag_in  (rd_tag),
        .rd_data (rd_data),
        .busy    (dist_busy),
        .best    (best)
    );

endmodule

// ----- sv/wnpm_checker.sv -----
`timescale 1ns / 1ps

module wnpm_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_cmd,
    input logic rsp_valid,
    input logic rsp_ready
);

    logic load_accept;
    logic query_accept;

    assign load_accept  = req_valid && req_ready && (req_cmd == wnpm_pkg::CMD_LOAD);
    assign query_accept = req_valid && req_ready && (req_cmd == wnpm_pkg::CMD_QUERY);

    // A pending response holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // A query occupies the block, so the next request must wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        query_accept |=> !req_ready)
        else $error("request taken while a query is in progress");

    // A load leaves the block ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_accept |=> req_ready)
        else $error("load request stalled the block");

    // A load never produces a response.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_accept && !rsp_valid |=> !rsp_valid)
        else $error("response appeared after a load request");

    // A new response is only issued while the block is busy with a query.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response appeared while the block was idle");

endmodule

bind windowed_nearest_point_match wnpm_checker u_wnpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);
